// ===== hw/rtl/hrhs_pkg.sv =====
// shared constants, codes and name-table helpers for the http request header scanner
`default_nettype none

package hrhs_pkg;

   // header length limit and derived byte counter width
   localparam int HEADER_MAX = 8192;
   localparam int BYTE_CNT_W = $clog2(HEADER_MAX);

   // field widths
   localparam int DATA_W     = 8;
   localparam int LEN13_W    = 13;
   localparam int BODY_W     = 19;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 19;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTRA_CAP  = 1'd1;

   // register reset values
   localparam logic [BODY_W-1:0]  BODY_LIMIT_RST = 19'd262144;
   localparam logic [LEN13_W-1:0] EXTRA_CAP_RST  = 13'd2048;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HDR_LONG  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BODY_BIG  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EXTRA_OVF = 2'd3;

   // parser phase codes
   localparam logic [1:0] PH_REQ  = 2'd0;
   localparam logic [1:0] PH_HDR  = 2'd1;
   localparam logic [1:0] PH_STOP = 2'd2;

   // content-length value parse codes
   localparam logic [1:0] LP_NONE  = 2'd0;
   localparam logic [1:0] LP_BLANK = 2'd1;
   localparam logic [1:0] LP_DIGIT = 2'd2;
   localparam logic [1:0] LP_DONE  = 2'd3;

   // character codes
   localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
   localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
   localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
   localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
   localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [DATA_W-1:0] CH_NINE  = 8'h39;
   localparam logic [DATA_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [DATA_W-1:0] CH_UP_Z  = 8'h5A;

   // dropped header names, lower case; content-length sits first
   localparam int NAME_COUNT   = 6;
   localparam int NAME_LEN_MAX = 18;
   localparam int CL_INDEX     = 0;
   localparam int POS_W        = 5;
   localparam logic [POS_W-1:0] POS_LIMIT = 5'd31;

   localparam logic [NAME_LEN_MAX*8-1:0] NAME_TEXT [NAME_COUNT] = '{
      "content-length:",
      "host:",
      "user-agent:",
      "accept:",
      "connection:",
      "transfer-encoding:"
   };

   localparam logic [POS_W-1:0] NAME_LEN [NAME_COUNT] = '{
      5'd15, 5'd5, 5'd11, 5'd7, 5'd11, 5'd18
   };

   // strings sit right-justified in the vector, first character highest
   function automatic logic [DATA_W-1:0] name_char(input int k, input logic [POS_W-1:0] p);
      int idx;
      idx = int'(NAME_LEN[k]) - 1 - int'(p);
      if (p < NAME_LEN[k]) begin
         return NAME_TEXT[k][idx*8 +: 8];
      end
      return '0;
   endfunction

   function automatic logic [DATA_W-1:0] to_lower(input logic [DATA_W-1:0] c);
      if (c >= CH_UP_A && c <= CH_UP_Z) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic logic is_digit(input logic [DATA_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/http_request_header_scanner.sv =====
// top level of the http request header scanner: one byte in, one result out
//
//  channel | ports                  | direction | transfer
//  --------+------------------------+-----------+------------------------------
//  req     | req_valid/req_ready    | in        | one request byte per item
//  rsp     | rsp_valid/rsp_ready    | out       | one result item per byte
//  csr     | csr_write_en/index/data| in        | register write, no wait
//
// for every item, the byte and the parser state feed one pass of logic whose
// outcome is loaded into the result register at the same edge as the parser state
// rsp_valid rises in the cycle after a byte is accepted; a byte can be taken
// every cycle unless a result is stuck; the result register is the only buffer:
// req_ready drops only while a result waits and rsp_ready is low
// reset (synchronous, active high) clears the parser and sets the registers to
// body_limit 262144 and extra_capacity 2048
`default_nettype none

module http_request_header_scanner
   import hrhs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration writes
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // request byte stream
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_start_req,
   input  wire logic [DATA_W-1:0]     req_data_byte,
   // result stream
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_line_done,
   output logic                       rsp_line_keep,
   output logic [LEN13_W-1:0]         rsp_line_bytes,
   output logic                       rsp_header_done,
   output logic [LEN13_W-1:0]         rsp_header_bytes,
   output logic [BODY_W-1:0]          rsp_body_length,
   output logic [LEN13_W-1:0]         rsp_extra_bytes,
   output logic [STATUS_W-1:0]        rsp_status
);

   // configuration registers
   logic [BODY_W-1:0]  body_limit_ff;
   logic [LEN13_W-1:0] extra_cap_ff;

   // parser state
   logic [1:0]            phase_ff,       phase_in;
   logic [1:0]            term_prog_ff,   term_prog_in;
   logic [BYTE_CNT_W-1:0] byte_cnt_ff,    byte_cnt_in;
   logic [LEN13_W-1:0]    line_size_ff,   line_size_in;
   logic                  last_cr_ff,     last_cr_in;
   logic [NAME_COUNT-1:0] prefix_alive_ff, prefix_alive_in;
   logic [POS_W-1:0]      prefix_pos_ff,  prefix_pos_in;
   logic [1:0]            len_phase_ff,   len_phase_in;
   logic [BODY_W-1:0]     len_value_ff,   len_value_in;
   logic [LEN13_W-1:0]    fwd_cnt_ff,     fwd_cnt_in;
   logic                  overflow_ff,    overflow_in;
   logic [STATUS_W-1:0]   status_ff,      status_in;

   // result register
   logic                  rsp_valid_ff,   rsp_valid_in;
   logic                  line_done_ff,   line_done_in;
   logic                  line_keep_ff,   line_keep_in;
   logic [LEN13_W-1:0]    line_bytes_ff,  line_bytes_in;
   logic                  hdr_done_ff,    hdr_done_in;
   logic [LEN13_W-1:0]    hdr_bytes_ff,   hdr_bytes_in;

   // per-byte working values
   logic                  req_accept;
   logic [DATA_W-1:0]     lc_byte;
   logic [2:0]            term_next;
   logic [BODY_W-1:0]     len_cap;
   logic [BODY_W+3:0]     len_mac;
   logic [LEN13_W-1:0]    line_net;
   logic [LEN13_W+1:0]    fwd_sum;
   logic                  line_drop;
   logic                  bc_limit;

   assign req_accept = req_valid && req_ready;
   // the result register parts the two sides: take a byte unless a result is stuck
   assign req_ready  = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         body_limit_ff <= BODY_LIMIT_RST;
         extra_cap_ff  <= EXTRA_CAP_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BODY_LIMIT: body_limit_ff <= csr_wdata;
            CSR_EXTRA_CAP:  extra_cap_ff  <= csr_wdata[LEN13_W-1:0];
            default: ;
         endcase
      end
   end

   // saturation point of the length digits: one past the limit, capped at 19 bits
   assign len_cap = (body_limit_ff == '1) ? '1 : body_limit_ff + 1'b1;
   assign lc_byte = to_lower(req_data_byte);

   // ---------------------------------------------------------------------------
   // single pass over one byte
   // ---------------------------------------------------------------------------
   always_comb begin
      // start of a request clears the parser before the byte is looked at
      phase_in        = req_start_req ? PH_REQ  : phase_ff;
      term_prog_in    = req_start_req ? 2'd0    : term_prog_ff;
      byte_cnt_in     = req_start_req ? '0      : byte_cnt_ff;
      line_size_in    = req_start_req ? '0      : line_size_ff;
      last_cr_in      = req_start_req ? 1'b0    : last_cr_ff;
      prefix_alive_in = req_start_req ? '1      : prefix_alive_ff;
      prefix_pos_in   = req_start_req ? '0      : prefix_pos_ff;
      len_phase_in    = req_start_req ? LP_NONE : len_phase_ff;
      len_value_in    = req_start_req ? '0      : len_value_ff;
      fwd_cnt_in      = req_start_req ? '0      : fwd_cnt_ff;
      overflow_in     = req_start_req ? 1'b0    : overflow_ff;
      status_in       = req_start_req ? STATUS_OK : status_ff;

      line_done_in  = 1'b0;
      line_keep_in  = 1'b0;
      line_bytes_in = '0;
      hdr_done_in   = 1'b0;
      hdr_bytes_in  = '0;

      term_next = 3'd0;
      len_mac   = '0;
      line_net  = '0;
      fwd_sum   = '0;
      line_drop = 1'b0;
      bc_limit  = 1'b0;

      if (phase_in == PH_REQ || phase_in == PH_HDR) begin
         byte_cnt_in = byte_cnt_in + 1'b1;

         // blank-line terminator tracking
         if (req_data_byte == CH_CR) begin
            term_next = (term_prog_in == 2'd2) ? 3'd3 : 3'd1;
         end else if (req_data_byte == CH_LF && term_prog_in == 2'd1) begin
            term_next = 3'd2;
         end else if (req_data_byte == CH_LF && term_prog_in == 2'd3) begin
            term_next = 3'd4;
         end

         // content-length value: skip blanks, then accumulate digits
         if (phase_in == PH_HDR) begin
            len_mac = (BODY_W+4)'({len_value_in, 3'b000})
                    + (BODY_W+4)'({len_value_in, 1'b0})
                    + (BODY_W+4)'(req_data_byte - CH_ZERO);
            if (len_phase_in == LP_BLANK) begin
               if (is_digit(req_data_byte)) begin
                  len_value_in = BODY_W'(req_data_byte - CH_ZERO);
                  len_phase_in = LP_DIGIT;
               end else if (req_data_byte != CH_SPACE && req_data_byte != CH_TAB) begin
                  len_phase_in = LP_DONE;
               end
            end else if (len_phase_in == LP_DIGIT) begin
               if (is_digit(req_data_byte)) begin
                  len_value_in = (len_mac > (BODY_W+4)'(len_cap)) ? len_cap
                                                                  : len_mac[BODY_W-1:0];
               end else begin
                  len_phase_in = LP_DONE;
               end
            end
         end

         if (req_data_byte == CH_LF) begin
            // end of line: report it unless it closes the request line
            if (phase_in == PH_HDR) begin
               line_net  = line_size_in - LEN13_W'(last_cr_in && line_size_in != '0);
               line_drop = (line_net == '0);
               for (int k = 0; k < NAME_COUNT; k++) begin
                  if (prefix_alive_in[k] && prefix_pos_in >= NAME_LEN[k]) begin
                     line_drop = 1'b1;
                  end
               end
               line_done_in  = 1'b1;
               line_bytes_in = line_net;
               line_keep_in  = !line_drop;
               fwd_sum = (LEN13_W+2)'(fwd_cnt_in) + (LEN13_W+2)'(line_net)
                       + (LEN13_W+2)'(2);
               if (!line_drop && !overflow_in) begin
                  if (fwd_sum >= (LEN13_W+2)'(extra_cap_ff)) begin
                     overflow_in = 1'b1;
                  end else begin
                     fwd_cnt_in = fwd_sum[LEN13_W-1:0];
                  end
               end
            end
            phase_in        = PH_HDR;
            line_size_in    = '0;
            last_cr_in      = 1'b0;
            prefix_alive_in = '1;
            prefix_pos_in   = '0;
         end else begin
            // prefix match against the dropped names
            if (phase_in == PH_HDR && prefix_pos_in < POS_LIMIT) begin
               for (int k = 0; k < NAME_COUNT; k++) begin
                  if (prefix_pos_in < NAME_LEN[k] && lc_byte != name_char(k, prefix_pos_in)) begin
                     prefix_alive_in[k] = 1'b0;
                  end
               end
               if (len_phase_in == LP_NONE && prefix_pos_in == NAME_LEN[CL_INDEX] - 1'b1 &&
                   prefix_alive_in[CL_INDEX]) begin
                  len_phase_in = LP_BLANK;
               end
               prefix_pos_in = prefix_pos_in + 1'b1;
            end
            if (line_size_in != '1) begin
               line_size_in = line_size_in + 1'b1;
            end
            last_cr_in = (req_data_byte == CH_CR);
         end

         // header end, length limit, or overflow shows in the status
         bc_limit = (byte_cnt_in >= BYTE_CNT_W'(HEADER_MAX - 1));
         if (term_next == 3'd4) begin
            hdr_done_in  = 1'b1;
            hdr_bytes_in = LEN13_W'(byte_cnt_in);
            if (len_value_in > body_limit_ff) begin
               status_in = STATUS_BODY_BIG;
            end else if (overflow_in) begin
               status_in = STATUS_EXTRA_OVF;
            end else begin
               status_in = STATUS_OK;
            end
            phase_in = PH_STOP;
         end else if (bc_limit) begin
            status_in = STATUS_HDR_LONG;
            phase_in  = PH_STOP;
         end else if (overflow_in) begin
            status_in = STATUS_EXTRA_OVF;
         end
         // progress four only occurs with the stop, so two bits are kept
         term_prog_in = term_next[1:0];
      end
   end

   // ---------------------------------------------------------------------------
   // state and result registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_REQ;
         term_prog_ff    <= 2'd0;
         byte_cnt_ff     <= '0;
         line_size_ff    <= '0;
         last_cr_ff      <= 1'b0;
         prefix_alive_ff <= '1;
         prefix_pos_ff   <= '0;
         len_phase_ff    <= LP_NONE;
         len_value_ff    <= '0;
         fwd_cnt_ff      <= '0;
         overflow_ff     <= 1'b0;
         status_ff       <= STATUS_OK;
      end else if (req_accept) begin
         phase_ff        <= phase_in;
         term_prog_ff    <= term_prog_in;
         byte_cnt_ff     <= byte_cnt_in;
         line_size_ff    <= line_size_in;
         last_cr_ff      <= last_cr_in;
         prefix_alive_ff <= prefix_alive_in;
         prefix_pos_ff   <= prefix_pos_in;
         len_phase_ff    <= len_phase_in;
         len_value_ff    <= len_value_in;
         fwd_cnt_ff      <= fwd_cnt_in;
         overflow_ff     <= overflow_in;
         status_ff       <= status_in;
      end
   end

   // result valid: set by an accepted byte, cleared once the result is taken
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // per-line and per-header fields of the result item
   always_ff @(posedge clock) begin
      if (req_accept) begin
         line_done_ff  <= line_done_in;
         line_keep_ff  <= line_keep_in;
         line_bytes_ff <= line_bytes_in;
         hdr_done_ff   <= hdr_done_in;
         hdr_bytes_ff  <= hdr_bytes_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_done    = line_done_ff;
   assign rsp_line_keep    = line_keep_ff;
   assign rsp_line_bytes   = line_bytes_ff;
   assign rsp_header_done  = hdr_done_ff;
   assign rsp_header_bytes = hdr_bytes_ff;
   // running values come straight from the parser state, which changes only on accept
   assign rsp_body_length  = len_value_ff;
   assign rsp_extra_bytes  = fwd_cnt_ff;
   assign rsp_status       = status_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hrhs_checker.sv =====
// port-level checker for the http request header scanner, with its bind
`default_nettype none

module hrhs_checker
   import hrhs_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic                  rsp_line_done,
   input wire logic                  rsp_line_keep,
   input wire logic [LEN13_W-1:0]    rsp_line_bytes,
   input wire logic                  rsp_header_done,
   input wire logic [LEN13_W-1:0]    rsp_header_bytes,
   input wire logic [BODY_W-1:0]     rsp_body_length,
   input wire logic [STATUS_W-1:0]   rsp_status
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_bytes) &&
      $stable(rsp_header_bytes) && $stable(rsp_body_length) && $stable(rsp_status))
      else $error("result changed while stalled");

   // every accepted byte gives a result in the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no result");

   // line fields are zero unless a line ended
   a_line_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_done |-> !rsp_line_keep && rsp_line_bytes == '0)
      else $error("line fields set without line end");

   // header length only reported at header end
   a_hdr_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_header_done |-> rsp_header_bytes == '0)
      else $error("header length set without header end");

   // a completed header never reports the too-long error
   a_hdr_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_done |-> rsp_status != STATUS_HDR_LONG)
      else $error("too-long status at header end");

endmodule

bind http_request_header_scanner hrhs_checker u_hrhs_checker (.*);

`default_nettype wire
